// ===== hdl/svf_pkg.sv =====
package svf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int PROD_W   = 40;
    localparam int ACC_W    = 42;
    localparam int FRAC_W   = 24;
    localparam int INDEX_W  = 3;

    localparam logic [INDEX_W-1:0] REG_GT0      = 3'd0;
    localparam logic [INDEX_W-1:0] REG_GK0      = 3'd1;
    localparam logic [INDEX_W-1:0] REG_GT1      = 3'd2;
    localparam logic [INDEX_W-1:0] REG_GK1      = 3'd3;
    localparam logic [INDEX_W-1:0] REG_GT2      = 3'd4;
    localparam logic [INDEX_W-1:0] REG_MIX_HIGH = 3'd5;
    localparam logic [INDEX_W-1:0] REG_MIX_BAND = 3'd6;
    localparam logic [INDEX_W-1:0] REG_MIX_LOW  = 3'd7;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_GT0_T0,
        MUL_GK0_IC1,
        MUL_GT1_T0,
        MUL_GK1_IC1,
        MUL_GT2_T0,
        MUL_GT1_IC1,
        MUL_MH_V0,
        MUL_MB_V1,
        MUL_ML_V2
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        ST_NONE,
        ST_T0,
        ST_V0,
        ST_T1,
        ST_T2,
        ST_STATE,
        ST_OUT
    } st_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        st_op_t   st_op;
    } svf_cmd_t;

    localparam logic signed [ACC_W-1:0] S32_MAX = 42'sd2147483647;
    localparam logic signed [ACC_W-1:0] S32_MIN = -42'sd2147483648;
    localparam logic signed [ACC_W-1:0] S24_MAX = 42'sd8388607;
    localparam logic signed [ACC_W-1:0] S24_MIN = -42'sd8388608;

    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [COEF_W-1:0] r;
        if (x > S32_MAX)
        begin
            r = S32_MAX[COEF_W-1:0];
        end
        else if (x < S32_MIN)
        begin
            r = S32_MIN[COEF_W-1:0];
        end
        else
        begin
            r = x[COEF_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] x);
        logic signed [SAMPLE_W-1:0] r;
        if (x > S24_MAX)
        begin
            r = S24_MAX[SAMPLE_W-1:0];
        end
        else if (x < S24_MIN)
        begin
            r = S24_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            r = x[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/svf_stream_if.sv =====
interface svf_in_if
    import svf_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface svf_out_if
    import svf_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

// ===== hdl/tpt_state_variable_filter.sv =====
// Channel   Direction  Payload                 Transfer
// in_ch     sink       sample_in  (24b, Q1.23)  valid && ready
// out_ch    source     sample_out (24b, Q1.23)  valid && ready
// cfg       write      cfg_index, cfg_data     cfg_we
//
// Each sample runs through nine products that share a single 32x32 multiplier,
// issued one after another as the controller steps through its states.
// A new sample is taken only once the previous one has left its final step.
// Reset clears the coefficients, mix weights and both integrators.
// A result that is not taken stalls the next sample in its final step only.
module tpt_state_variable_filter
    import svf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    svf_in_if.sink             in_ch,
    svf_out_if.source          out_ch,
    input  logic               cfg_we,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]  cfg_data
);

    svf_cmd_t cmd;

    svf_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    svf_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample_in  (in_ch.sample_in),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_out (out_ch.sample_out)
    );

endmodule

// ===== hdl/svf_datapath.sv =====
module svf_datapath
    import svf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  svf_cmd_t                   cmd,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       cfg_we,
    input  logic [INDEX_W-1:0]         cfg_index,
    input  logic [COEF_W-1:0]          cfg_data,
    output logic signed [SAMPLE_W-1:0] sample_out
);

    logic signed [COEF_W-1:0] gt0_reg, gk0_reg, gt1_reg, gk1_reg, gt2_reg;
    logic signed [COEF_W-1:0] mh_reg, mb_reg, ml_reg;
    logic signed [COEF_W-1:0] ic1_reg, ic2_reg;
    logic signed [COEF_W-1:0] t0_reg, t1_reg, t2_reg, v0_reg, v1_reg, v2_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    logic signed [COEF_W-1:0]   mul_a, mul_b;
    logic signed [2*COEF_W-1:0] prod_full, prod_rnd;
    logic signed [ACC_W-1:0]    prod_ext, acc_diff, acc_sum;
    logic signed [ACC_W-1:0]    t0_wide, v1_wide, v2_wide, ic1_wide, ic2_wide, out_wide;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_GT0_T0:  begin mul_a = gt0_reg; mul_b = t0_reg;  end
            MUL_GK0_IC1: begin mul_a = gk0_reg; mul_b = ic1_reg; end
            MUL_GT1_T0:  begin mul_a = gt1_reg; mul_b = t0_reg;  end
            MUL_GK1_IC1: begin mul_a = gk1_reg; mul_b = ic1_reg; end
            MUL_GT2_T0:  begin mul_a = gt2_reg; mul_b = t0_reg;  end
            MUL_GT1_IC1: begin mul_a = gt1_reg; mul_b = ic1_reg; end
            MUL_MH_V0:   begin mul_a = mh_reg;  mul_b = v0_reg;  end
            MUL_MB_V1:   begin mul_a = mb_reg;  mul_b = v1_reg;  end
            MUL_ML_V2:   begin mul_a = ml_reg;  mul_b = v2_reg;  end
            default:     begin mul_a = '0;      mul_b = '0;      end
        endcase
    end

    // Full product with round half up, then an arithmetic shift by the fraction width.
    assign prod_full = mul_a * mul_b;
    assign prod_rnd  = prod_full + (64'sd1 <<< (FRAC_W - 1));
    assign prod_next = prod_rnd[2*COEF_W-1:FRAC_W];

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_diff = acc_reg - prod_ext;
    assign acc_sum  = acc_reg + prod_ext;

    assign t0_wide  = {{(ACC_W-SAMPLE_W-1){sample_in[SAMPLE_W-1]}}, sample_in, 1'b0}
                    - {{(ACC_W-COEF_W){ic2_reg[COEF_W-1]}}, ic2_reg};
    assign v1_wide  = {{(ACC_W-COEF_W){ic1_reg[COEF_W-1]}}, ic1_reg}
                    + {{(ACC_W-COEF_W){t1_reg[COEF_W-1]}}, t1_reg};
    assign v2_wide  = {{(ACC_W-COEF_W){ic2_reg[COEF_W-1]}}, ic2_reg}
                    + {{(ACC_W-COEF_W){t2_reg[COEF_W-1]}}, t2_reg};
    assign ic1_wide = v1_wide + {{(ACC_W-COEF_W){t1_reg[COEF_W-1]}}, t1_reg};
    assign ic2_wide = v2_wide + {{(ACC_W-COEF_W){t2_reg[COEF_W-1]}}, t2_reg};
    assign out_wide = (acc_reg + 42'sd1) >>> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt0_reg <= '0;
            gk0_reg <= '0;
            gt1_reg <= '0;
            gk1_reg <= '0;
            gt2_reg <= '0;
            mh_reg  <= '0;
            mb_reg  <= '0;
            ml_reg  <= '0;
            ic1_reg <= '0;
            ic2_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GT0:      gt0_reg <= cfg_data;
                    REG_GK0:      gk0_reg <= cfg_data;
                    REG_GT1:      gt1_reg <= cfg_data;
                    REG_GK1:      gk1_reg <= cfg_data;
                    REG_GT2:      gt2_reg <= cfg_data;
                    REG_MIX_HIGH: mh_reg  <= cfg_data;
                    REG_MIX_BAND: mb_reg  <= cfg_data;
                    REG_MIX_LOW:  ml_reg  <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.st_op == ST_STATE)
            begin
                ic1_reg <= sat32(ic1_wide);
                ic2_reg <= sat32(ic2_wide);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_sel != MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
        unique case (cmd.acc_op)
            ACC_LOAD: acc_reg <= prod_ext;
            ACC_ADD:  acc_reg <= acc_sum;
            default:  ;
        endcase
        unique case (cmd.st_op)
            ST_T0:    t0_reg <= sat32(t0_wide);
            ST_V0:    v0_reg <= sat32(acc_diff);
            ST_T1:    t1_reg <= sat32(acc_diff);
            ST_T2:    t2_reg <= sat32(acc_sum);
            ST_STATE:
            begin
                v1_reg <= sat32(v1_wide);
                v2_reg <= sat32(v2_wide);
            end
            ST_OUT:   sample_out_reg <= sat24(out_wide);
            default:  ;
        endcase
    end

    assign sample_out = sample_out_reg;

endmodule

// ===== hdl/svf_controller.sv =====
module svf_controller
    import svf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output svf_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GT0T0,
        S_GK0IC1,
        S_GT1T0,
        S_GK1IC1,
        S_GT2T0,
        S_GT1IC1,
        S_MHV0,
        S_STATE,
        S_MBV1,
        S_MLV2,
        S_SUM,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, st_op: ST_NONE};
        unique case (state_reg)
            S_IDLE:   cmd.st_op = in_valid ? ST_T0 : ST_NONE;
            S_GT0T0:  cmd.mul_sel = MUL_GT0_T0;
            S_GK0IC1: cmd = '{mul_sel: MUL_GK0_IC1, acc_op: ACC_LOAD, st_op: ST_NONE};
            S_GT1T0:  cmd = '{mul_sel: MUL_GT1_T0, acc_op: ACC_HOLD, st_op: ST_V0};
            S_GK1IC1: cmd = '{mul_sel: MUL_GK1_IC1, acc_op: ACC_LOAD, st_op: ST_NONE};
            S_GT2T0:  cmd = '{mul_sel: MUL_GT2_T0, acc_op: ACC_HOLD, st_op: ST_T1};
            S_GT1IC1: cmd = '{mul_sel: MUL_GT1_IC1, acc_op: ACC_LOAD, st_op: ST_NONE};
            S_MHV0:   cmd = '{mul_sel: MUL_MH_V0, acc_op: ACC_HOLD, st_op: ST_T2};
            S_STATE:  cmd = '{mul_sel: MUL_NONE, acc_op: ACC_LOAD, st_op: ST_STATE};
            S_MBV1:   cmd.mul_sel = MUL_MB_V1;
            S_MLV2:   cmd = '{mul_sel: MUL_ML_V2, acc_op: ACC_ADD, st_op: ST_NONE};
            S_SUM:    cmd.acc_op = ACC_ADD;
            S_OUT:    cmd.st_op = out_free ? ST_OUT : ST_NONE;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:   state_reg <= in_valid ? S_GT0T0 : S_IDLE;
                S_GT0T0:  state_reg <= S_GK0IC1;
                S_GK0IC1: state_reg <= S_GT1T0;
                S_GT1T0:  state_reg <= S_GK1IC1;
                S_GK1IC1: state_reg <= S_GT2T0;
                S_GT2T0:  state_reg <= S_GT1IC1;
                S_GT1IC1: state_reg <= S_MHV0;
                S_MHV0:   state_reg <= S_STATE;
                S_STATE:  state_reg <= S_MBV1;
                S_MBV1:   state_reg <= S_MLV2;
                S_MLV2:   state_reg <= S_SUM;
                S_SUM:    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/svf_checker.sv =====
module svf_checker
    import svf_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] out_sample
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_sample))
        else $error("result changed while stalled");

    // After an input transfer the block is busy for the following cycle.
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // A new result never appears right after an input transfer.
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind tpt_state_variable_filter svf_checker u_svf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.sample_out)
);

// ===== tb/sv/tb_tpt_state_variable_filter.sv =====
module tb_tpt_state_variable_filter;
    import svf_pkg::*;

    typedef enum int {
        MODE_LOW,
        MODE_HIGH,
        MODE_BAND,
        MODE_NOTCH,
        MODE_PEAK,
        MODE_BELL,
        MODE_SHELF
    } svf_mode_e;

    localparam longint Q32_HI = 64'sd2147483647;
    localparam longint Q32_LO = -64'sd2147483648;
    localparam longint Q24_HI = 64'sd8388607;
    localparam longint Q24_LO = -64'sd8388608;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;
    localparam int IDLE_PCT = 18;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES = 9;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [INDEX_W-1:0] cfg_index;
    logic [COEF_W-1:0] cfg_data;

    svf_in_if in_if ();
    svf_out_if out_if ();

    tpt_state_variable_filter dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_if),
        .out_ch(out_if),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    longint coef_q824 [8];
    longint integ_one;
    longint integ_two;

    logic signed [SAMPLE_W-1:0] samples_pending [$];
    logic signed [SAMPLE_W-1:0] samples_expected [$];
    logic signed [SAMPLE_W-1:0] want_sample;
    int samples_owed;
    int errors;
    bit calm;

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic longint clamp_q32(input longint v);
        return clamp_to(v, Q32_LO, Q32_HI);
    endfunction

    // Q8.24 product, rounded half up.
    function automatic longint qprod(input longint a, input longint b);
        return (a * b + 64'sd8388608) >>> 24;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] filter_step(
        input logic signed [SAMPLE_W-1:0] s
    );
        longint ic1;
        longint ic2;
        longint t0;
        longint v0;
        longint t1;
        longint t2;
        longint v1;
        longint v2;
        longint y;
        ic1 = integ_one;
        ic2 = integ_two;
        t0 = clamp_q32(longint'(s) * 2 - ic2);
        v0 = clamp_q32(qprod(coef_q824[REG_GT0], t0) - qprod(coef_q824[REG_GK0], ic1));
        t1 = clamp_q32(qprod(coef_q824[REG_GT1], t0) - qprod(coef_q824[REG_GK1], ic1));
        t2 = clamp_q32(qprod(coef_q824[REG_GT2], t0) + qprod(coef_q824[REG_GT1], ic1));
        v1 = clamp_q32(ic1 + t1);
        v2 = clamp_q32(ic2 + t2);
        integ_one = clamp_q32(ic1 + 2 * t1);
        integ_two = clamp_q32(ic2 + 2 * t2);
        y = qprod(coef_q824[REG_MIX_HIGH], v0) + qprod(coef_q824[REG_MIX_BAND], v1)
            + qprod(coef_q824[REG_MIX_LOW], v2);
        y = clamp_to((y + 1) >>> 1, Q24_LO, Q24_HI);
        return y[SAMPLE_W-1:0];
    endfunction

    function automatic logic [COEF_W-1:0] to_q824(input real v);
        return 32'($rtoi(v * 16777216.0));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return SAMPLE_W'($urandom);
        end
        if (r < 85)
        begin
            return SAMPLE_W'($signed($urandom_range(0, 131071)) - 65536);
        end
        if (r < 95)
        begin
            return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
        end
        return SAMPLE_W'($signed($urandom_range(0, 2)) - 1);
    endfunction

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        coef_q824[idx] = longint'($signed(val));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_all(
        input logic [COEF_W-1:0] gt0, input logic [COEF_W-1:0] gk0,
        input logic [COEF_W-1:0] gt1, input logic [COEF_W-1:0] gk1,
        input logic [COEF_W-1:0] gt2, input logic [COEF_W-1:0] mh,
        input logic [COEF_W-1:0] mb, input logic [COEF_W-1:0] ml
    );
        write_reg(REG_GT0, gt0);
        write_reg(REG_GK0, gk0);
        write_reg(REG_GT1, gt1);
        write_reg(REG_GK1, gk1);
        write_reg(REG_GT2, gt2);
        write_reg(REG_MIX_HIGH, mh);
        write_reg(REG_MIX_BAND, mb);
        write_reg(REG_MIX_LOW, ml);
    endtask

    // Coefficients follow from the prewarped gain g and the damping k.
    task automatic set_mode(input svf_mode_e mode, input real g, input real k);
        real a1;
        real mh;
        real mb;
        real ml;
        a1 = 1.0 / (1.0 + g * (g + k));
        mh = 0.0;
        mb = 0.0;
        ml = 0.0;
        case (mode)
            MODE_LOW:   ml = 1.0;
            MODE_HIGH:  mh = 1.0;
            MODE_BAND:  mb = k;
            MODE_NOTCH:
            begin
                mh = 1.0;
                ml = 1.0;
            end
            MODE_PEAK:
            begin
                mh = 1.0;
                ml = -1.0;
            end
            MODE_BELL:
            begin
                mh = 1.0;
                mb = 2.0 * k;
                ml = 1.0;
            end
            default:
            begin
                mh = 1.0;
                mb = 1.4 * k;
                ml = 2.0;
            end
        endcase
        load_all(to_q824(a1), to_q824((g + k) * a1), to_q824(g * a1),
            to_q824(g * (g + k) * a1), to_q824(g * g * a1),
            to_q824(mh), to_q824(mb), to_q824(ml));
    endtask

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] s);
        samples_owed++;
        samples_pending.push_back(s);
    endtask

    task automatic drain();
        while (samples_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                samples_expected.push_back(filter_step(in_if.sample_in));
            end
            if (!in_if.valid || in_if.ready)
            begin
                if (samples_pending.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_if.valid <= 1'b1;
                    in_if.sample_in <= samples_pending.pop_front();
                end
                else
                begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (samples_expected.size() == 0)
                begin
                    $display("%0t: unexpected sample_out, expected none, actual %0d",
                        $time, out_if.sample_out);
                    errors++;
                end
                else
                begin
                    want_sample = samples_expected.pop_front();
                    samples_owed--;
                    if (out_if.sample_out !== want_sample)
                    begin
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                            $time, want_sample, out_if.sample_out);
                        errors++;
                    end
                end
            end
            out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        int p;
        int i;
        real g;
        real k;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.sample_in = '0;
        out_if.ready = 1'b0;
        errors = 0;
        samples_owed = 0;
        calm = 1'b0;
        integ_one = 0;
        integ_two = 0;
        for (i = 0; i < 8; i++)
        begin
            coef_q824[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // With reset coefficients every output is zero.
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        drain();

        // Full-scale steps and alternation through a low-pass.
        set_mode(MODE_LOW, 0.2, 0.707);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MIN);
        queue_sample('0);
        queue_sample(24'sd1);
        queue_sample(-24'sd1);
        for (i = 0; i < 4; i++)
        begin
            queue_sample(SAMPLE_MAX);
            queue_sample(SAMPLE_MIN);
        end
        drain();

        // Extreme gains drive the integrators and the output into saturation.
        load_all(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
            COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MAX);
        drain();
        load_all(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
            COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MIN);
        drain();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            g = 0.01 + $urandom_range(0, 2000) / 1000.0;
            k = 0.05 + $urandom_range(0, 1500) / 1000.0;
            if (p == 4)
            begin
                load_all($urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
            end
            else if (p == 8)
            begin
                load_all(32'($signed(26'($urandom))), 32'($signed(26'($urandom))),
                    32'($signed(26'($urandom))), 32'($signed(26'($urandom))),
                    32'($signed(26'($urandom))), 32'($signed(26'($urandom))),
                    32'($signed(26'($urandom))), 32'($signed(26'($urandom))));
            end
            else
            begin
                set_mode(svf_mode_e'(p % 7), g, k);
            end
            calm = (p == 2);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                queue_sample(pick_sample());
                if (p == 2 && i == PHASE_ITEMS / 2)
                begin
                    drain();
                end
            end
            drain();
            calm = 1'b0;
        end

        if (samples_expected.size() != 0)
        begin
            $display("%0t: %0d expected sample_out values never arrived",
                $time, samples_expected.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/svf_pkg.sv
hdl/svf_stream_if.sv
hdl/svf_datapath.sv
hdl/svf_controller.sv
hdl/tpt_state_variable_filter.sv
hdl/svf_checker.sv
tb/sv/tb_tpt_state_variable_filter.sv
